// ===== sv/eidst_pkg.sv =====
`timescale 1ns / 1ps

package eidst_pkg;

    // Table size
    localparam int ENTITY_COUNT   = 32;
    localparam int COMPONENT_BITS = 32;

    // Widths of the fields on the ports
    localparam int REQ_W    = 3;
    localparam int ENT_W    = 5;
    localparam int COMP_W   = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 6;

    // Internal widths
    localparam int EIDX_W = $clog2(ENTITY_COUNT);
    localparam int CNT_W  = $clog2(ENTITY_COUNT + 1);
    localparam int SIG_W  = COMPONENT_BITS;

    typedef logic [EIDX_W-1:0] eidx_t;
    typedef logic [EIDX_W:0]   scan_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SIG_W-1:0]  sig_t;

    localparam scan_t SCAN_END  = scan_t'(ENTITY_COUNT);
    localparam cnt_t  CNT_FULL  = cnt_t'(ENTITY_COUNT);
    localparam eidx_t EIDX_LAST = eidx_t'(ENTITY_COUNT - 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CREATE  = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_DESTROY = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_ADD     = REQ_W'(2);
    localparam logic [REQ_W-1:0] REQ_SET     = REQ_W'(3);
    localparam logic [REQ_W-1:0] REQ_READ    = REQ_W'(4);
    localparam logic [REQ_W-1:0] REQ_QUERY   = REQ_W'(5);

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_ALL_FREE = STATUS_W'(2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINAL
    } state_t;

    // Sequencer to free-id queue
    typedef struct packed {
        logic  rd_en;
        logic  pop;
        logic  push;
        eidx_t push_id;
    } fq_ctrl_t;

    // Free-id queue back to sequencer
    typedef struct packed {
        eidx_t head_id;
        cnt_t  free_count;
    } fq_stat_t;

    function automatic eidx_t ring_next(input eidx_t p);
        eidx_t r;
        if (p == EIDX_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + eidx_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== sv/eidst_if.sv =====
`timescale 1ns / 1ps

interface eidst_req_if;
    logic                          valid;
    logic                          ready;
    logic [eidst_pkg::REQ_W-1:0]   req_type;
    logic [eidst_pkg::ENT_W-1:0]   entity_id;
    logic [eidst_pkg::COMP_W-1:0]  component_id;
    logic [eidst_pkg::VAL_W-1:0]   signature_value;

    modport source (
        output valid, req_type, entity_id, component_id, signature_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, entity_id, component_id, signature_value,
        output ready
    );
endinterface

interface eidst_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [eidst_pkg::STATUS_W-1:0]  status;
    logic [eidst_pkg::ENT_W-1:0]     result_entity;
    logic                            match_found;
    logic [eidst_pkg::VAL_W-1:0]     signature_out;
    logic [eidst_pkg::LIVE_W-1:0]    living_count;
    logic                            last;

    modport source (
        output valid, status, result_entity, match_found, signature_out,
               living_count, last,
        input  ready
    );

    modport sink (
        input  valid, status, result_entity, match_found, signature_out,
               living_count, last,
        output ready
    );
endinterface

// ===== sv/eidst_ram.sv =====
`timescale 1ns / 1ps

module eidst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/eidst_freeq.sv =====
`timescale 1ns / 1ps

module eidst_freeq (
    input  logic                clk,
    input  logic                rst_n,
    input  eidst_pkg::fq_ctrl_t ctrl,
    output eidst_pkg::fq_stat_t stat
);

    eidst_pkg::eidx_t head_reg;
    eidst_pkg::eidx_t head_next;
    eidst_pkg::eidx_t tail_reg;
    eidst_pkg::eidx_t tail_next;
    eidst_pkg::cnt_t  cnt_reg;
    eidst_pkg::cnt_t  cnt_next;

    // Entry never written still holds its reset id, which equals its index
    logic [eidst_pkg::ENTITY_COUNT-1:0] vld_reg;
    logic                               rd_vld_reg;
    eidst_pkg::eidx_t                   rd_addr_reg;
    eidst_pkg::eidx_t                   ram_q;

    eidst_ram #(
        .WIDTH (eidst_pkg::EIDX_W),
        .DEPTH (eidst_pkg::ENTITY_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.push),
        .waddr (tail_reg),
        .wdata (ctrl.push_id),
        .re    (ctrl.rd_en),
        .raddr (head_reg),
        .rdata (ram_q)
    );

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (ctrl.pop)
        begin
            head_next = eidst_pkg::ring_next(head_reg);
            cnt_next  = cnt_reg - eidst_pkg::cnt_t'(1);
        end
        if (ctrl.push)
        begin
            tail_next = eidst_pkg::ring_next(tail_reg);
            cnt_next  = cnt_reg + eidst_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= eidst_pkg::CNT_FULL;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            if (ctrl.push)
            begin
                vld_reg[tail_reg] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_vld_reg  <= vld_reg[head_reg];
                rd_addr_reg <= head_reg;
            end
        end
    end

    assign stat.head_id    = rd_vld_reg ? ram_q : rd_addr_reg;
    assign stat.free_count = cnt_reg;

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (cnt_reg != '0))
        else $error("pop from empty free-id queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> (cnt_reg != eidst_pkg::CNT_FULL))
        else $error("push into full free-id queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != eidst_pkg::CNT_FULL) |-> (head_reg != tail_reg))
        else $error("free-id pointers meet while queue partly full");

endmodule

// ===== sv/entity_id_allocator_signature_table.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Beat fields
// --------+-----+----------------------------------------------------------
// req     | in  | req_type, entity_id, component_id, signature_value
// rsp     | out | status, result_entity, match_found, signature_out,
//         |     | living_count, last
//
// Create, destroy, add, set, read: accept, then execute on the registered
// read of the signature and free-id memories; one rsp beat. Query: one read
// per cycle on the single signature memory read port, except while a new
// hit waits on a held rsp beat; one rsp beat per match, or one without.
// Reset clears all control state at once; per-entry valid bits stand in for
// the cleared signature memory and the initial free-id order, so no sweep.
// A held rsp beat stalls execution only when a new beat must be loaded.

module entity_id_allocator_signature_table (
    input  logic       clk,
    input  logic       rst_n,
    eidst_req_if.sink  req,
    eidst_rsp_if.source rsp
);

    eidst_pkg::state_t state_reg;
    eidst_pkg::state_t state_next;

    // Latched request
    logic [eidst_pkg::REQ_W-1:0]  req_type_reg;
    logic [eidst_pkg::ENT_W-1:0]  ent_reg;
    logic [eidst_pkg::COMP_W-1:0] comp_reg;
    logic [eidst_pkg::VAL_W-1:0]  val_reg;

    eidst_pkg::cnt_t  live_reg;
    eidst_pkg::cnt_t  live_next;

    // Query walk
    eidst_pkg::scan_t scan_idx_reg;
    eidst_pkg::scan_t scan_idx_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    eidst_pkg::eidx_t rd_idx_reg;
    eidst_pkg::eidx_t rd_idx_next;
    logic             hit_reg;
    logic             hit_next;
    eidst_pkg::eidx_t hit_id_reg;
    eidst_pkg::eidx_t hit_id_next;

    // Signature memory
    logic [eidst_pkg::ENTITY_COUNT-1:0] sig_vld_reg;
    logic                               sig_rd_vld_reg;
    logic                               sig_we;
    eidst_pkg::eidx_t                   sig_waddr;
    eidst_pkg::sig_t                    sig_wdata;
    logic                               sig_re;
    eidst_pkg::eidx_t                   sig_raddr;
    eidst_pkg::sig_t                    sig_q;
    eidst_pkg::sig_t                    sig_rd;

    eidst_pkg::fq_ctrl_t fq_ctrl;
    eidst_pkg::fq_stat_t fq_stat;

    // Output stage
    logic                            out_vld_reg;
    logic                            out_free;
    logic                            out_load;
    logic [eidst_pkg::STATUS_W-1:0]  out_status_reg;
    logic [eidst_pkg::ENT_W-1:0]     out_ent_reg;
    logic                            out_match_reg;
    logic [eidst_pkg::VAL_W-1:0]     out_sig_reg;
    logic [eidst_pkg::LIVE_W-1:0]    out_live_reg;
    logic                            out_last_reg;
    logic [eidst_pkg::STATUS_W-1:0]  out_status_next;
    logic [eidst_pkg::ENT_W-1:0]     out_ent_next;
    logic                            out_match_next;
    logic [eidst_pkg::VAL_W-1:0]     out_sig_next;
    logic [eidst_pkg::LIVE_W-1:0]    out_live_next;
    logic                            out_last_next;

    logic             accept;
    logic             ent_ok;
    logic             comp_ok;
    eidst_pkg::eidx_t ent_idx;
    eidst_pkg::sig_t  comp_mask;
    logic             scan_hit;
    logic             scan_stall;

    eidst_ram #(
        .WIDTH (eidst_pkg::SIG_W),
        .DEPTH (eidst_pkg::ENTITY_COUNT)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .re    (sig_re),
        .raddr (sig_raddr),
        .rdata (sig_q)
    );

    eidst_freeq u_freeq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fq_ctrl),
        .stat  (fq_stat)
    );

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == eidst_pkg::S_IDLE);
    assign out_free  = !out_vld_reg || rsp.ready;

    assign ent_ok    = (int'(ent_reg) < eidst_pkg::ENTITY_COUNT);
    assign comp_ok   = (int'(comp_reg) < eidst_pkg::COMPONENT_BITS);
    assign ent_idx   = eidst_pkg::eidx_t'(ent_reg);
    assign sig_rd    = sig_rd_vld_reg ? sig_q : '0;

    // Shared bit-select shifter: add sets this bit, query tests it
    assign comp_mask = eidst_pkg::sig_t'(1) << comp_reg;
    assign scan_hit  = rd_pend_reg && ((sig_rd & comp_mask) != '0);
    // a new hit must push out the pending one
    assign scan_stall = scan_hit && hit_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = rd_pend_reg;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_id_next     = hit_id_reg;
        sig_we          = 1'b0;
        sig_waddr       = ent_idx;
        sig_wdata       = '0;
        sig_re          = 1'b0;
        sig_raddr       = eidst_pkg::eidx_t'(req.entity_id);
        fq_ctrl         = '0;
        fq_ctrl.push_id = ent_idx;
        out_load        = 1'b0;
        out_status_next = eidst_pkg::ST_OK;
        out_ent_next    = '0;
        out_match_next  = 1'b0;
        out_sig_next    = '0;
        out_live_next   = eidst_pkg::LIVE_W'(live_reg);
        out_last_next   = 1'b1;

        unique case (state_reg)
            eidst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    sig_re        = 1'b1;
                    fq_ctrl.rd_en = 1'b1;
                    if (req.req_type == eidst_pkg::REQ_QUERY)
                    begin
                        scan_idx_next = '0;
                        rd_pend_next  = 1'b0;
                        hit_next      = 1'b0;
                        state_next    = eidst_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = eidst_pkg::S_EXEC;
                    end
                end
            end

            eidst_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = eidst_pkg::S_IDLE;
                    unique case (req_type_reg)
                        eidst_pkg::REQ_CREATE:
                        begin
                            if (fq_stat.free_count == '0)
                            begin
                                out_status_next = eidst_pkg::ST_NO_FREE;
                            end
                            else
                            begin
                                out_ent_next = eidst_pkg::ENT_W'(fq_stat.head_id);
                                fq_ctrl.pop  = 1'b1;
                                live_next    = live_reg + eidst_pkg::cnt_t'(1);
                            end
                        end
                        eidst_pkg::REQ_DESTROY:
                        begin
                            if (fq_stat.free_count >= eidst_pkg::CNT_FULL)
                            begin
                                out_status_next = eidst_pkg::ST_ALL_FREE;
                            end
                            else if (ent_ok)
                            begin
                                sig_we       = 1'b1;
                                sig_wdata    = '0;
                                fq_ctrl.push = 1'b1;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - eidst_pkg::cnt_t'(1);
                                end
                            end
                        end
                        eidst_pkg::REQ_ADD:
                        begin
                            if (ent_ok && comp_ok)
                            begin
                                sig_we    = 1'b1;
                                sig_wdata = sig_rd | comp_mask;
                            end
                        end
                        eidst_pkg::REQ_SET:
                        begin
                            if (ent_ok)
                            begin
                                sig_we    = 1'b1;
                                sig_wdata = eidst_pkg::sig_t'(val_reg);
                            end
                        end
                        eidst_pkg::REQ_READ:
                        begin
                            if (ent_ok)
                            begin
                                out_sig_next = eidst_pkg::VAL_W'(sig_rd);
                            end
                        end
                        default:
                        begin
                            out_status_next = eidst_pkg::ST_OK;
                        end
                    endcase
                    out_live_next = eidst_pkg::LIVE_W'(live_next);
                end
            end

            eidst_pkg::S_SCAN:
            begin
                sig_raddr = eidst_pkg::eidx_t'(scan_idx_reg);
                if (!scan_stall)
                begin
                    if (scan_idx_reg != eidst_pkg::SCAN_END)
                    begin
                        sig_re        = 1'b1;
                        scan_idx_next = scan_idx_reg + eidst_pkg::scan_t'(1);
                        rd_pend_next  = 1'b1;
                        rd_idx_next   = eidst_pkg::eidx_t'(scan_idx_reg);
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                    end
                    if (scan_hit)
                    begin
                        // previous hit is known not to be the final one
                        if (hit_reg)
                        begin
                            out_load       = 1'b1;
                            out_ent_next   = eidst_pkg::ENT_W'(hit_id_reg);
                            out_match_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        hit_next    = 1'b1;
                        hit_id_next = rd_idx_reg;
                    end
                    if (scan_idx_reg == eidst_pkg::SCAN_END && !rd_pend_reg)
                    begin
                        state_next = eidst_pkg::S_FINAL;
                    end
                end
            end

            eidst_pkg::S_FINAL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = eidst_pkg::S_IDLE;
                    if (hit_reg)
                    begin
                        out_ent_next   = eidst_pkg::ENT_W'(hit_id_reg);
                        out_match_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = eidst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= eidst_pkg::S_IDLE;
            live_reg       <= '0;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            hit_reg        <= 1'b0;
            hit_id_reg     <= '0;
            sig_vld_reg    <= '0;
            sig_rd_vld_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            scan_idx_reg <= scan_idx_next;
            rd_pend_reg  <= rd_pend_next;
            rd_idx_reg   <= rd_idx_next;
            hit_reg      <= hit_next;
            hit_id_reg   <= hit_id_next;
            if (sig_we)
            begin
                sig_vld_reg[sig_waddr] <= 1'b1;
            end
            if (sig_re)
            begin
                sig_rd_vld_reg <= sig_vld_reg[sig_raddr];
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            ent_reg      <= req.entity_id;
            comp_reg     <= req.component_id;
            val_reg      <= req.signature_value;
        end
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_ent_reg    <= out_ent_next;
            out_match_reg  <= out_match_next;
            out_sig_reg    <= out_sig_next;
            out_live_reg   <= out_live_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_entity = out_ent_reg;
    assign rsp.match_found   = out_match_reg;
    assign rsp.signature_out = out_sig_reg;
    assign rsp.living_count  = out_live_reg;
    assign rsp.last          = out_last_reg;

    a_id_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, live_reg} + {1'b0, fq_stat.free_count}) ==
        (eidst_pkg::CNT_W + 1)'(eidst_pkg::ENTITY_COUNT))
        else $error("live and free id counts out of balance");

    a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.match_found) |-> rsp.last)
        else $error("beat without match is not the final one");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == eidst_pkg::S_EXEC || state_reg == eidst_pkg::S_SCAN))
        else $error("accepted request not dispatched");

    a_final_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == eidst_pkg::S_FINAL) |-> (!rd_pend_reg &&
        scan_idx_reg == eidst_pkg::SCAN_END))
        else $error("query finished with reads outstanding");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import eidst_pkg::*;

    // req_type codes the block has no operation for
    localparam logic [REQ_W-1:0] REQ_RSVD_A = REQ_W'(6);
    localparam logic [REQ_W-1:0] REQ_RSVD_B = REQ_W'(7);

    localparam int ENT_MAX      = (1 << ENT_W) - 1;
    localparam int COMP_MAX     = (1 << COMP_W) - 1;
    localparam int DRAIN_CYCLES = ENTITY_COUNT + 8;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ENT_W-1:0]    entity;
        logic                hit;
        logic [VAL_W-1:0]    sig;
        logic [LIVE_W-1:0]   live;
        logic                last;
    } rsp_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    eidst_req_if req_ch ();
    eidst_rsp_if rsp_ch ();

    entity_id_allocator_signature_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the allocator and signature table
    eidx_t     free_ring [ENTITY_COUNT];
    sig_t      sig_table [ENTITY_COUNT];
    int        ring_head;
    int        ring_tail;
    int        free_ids;
    int        live_total;
    rsp_beat_t pending_rsp [$];
    int        alive_ids [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_pending;
    int hold_cnt;
    int err_count;

    always #10 clk = ~clk;

    task automatic reset_table_model();
        for (int i = 0; i < ENTITY_COUNT; i++)
        begin
            free_ring[i] = eidx_t'(i);
            sig_table[i] = '0;
        end
        ring_head  = 0;
        ring_tail  = 0;
        free_ids   = ENTITY_COUNT;
        live_total = 0;
    endtask

    task automatic push_beat(input logic [STATUS_W-1:0] st, input int ent, input logic hit,
                             input logic [VAL_W-1:0] sig, input logic fin);
        rsp_beat_t b;
        b.status = st;
        b.entity = ENT_W'(ent);
        b.hit    = hit;
        b.sig    = sig;
        b.live   = LIVE_W'(live_total);
        b.last   = fin;
        pending_rsp.insert(pending_rsp.size(), b);
    endtask

    // Updates the shadow table for one accepted request and queues its beats
    task automatic apply_request(input logic [REQ_W-1:0] kind, input int ent, input int comp,
                                 input logic [VAL_W-1:0] val);
        bit ent_ok;
        bit comp_ok;
        int hits;
        int seen;
        int id;
        int found [$];
        ent_ok  = ent < ENTITY_COUNT;
        comp_ok = comp < COMPONENT_BITS;
        case (kind)
            REQ_CREATE:
            begin
                if (free_ids == 0)
                begin
                    push_beat(ST_NO_FREE, 0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    id = free_ring[ring_head];
                    ring_head = (ring_head + 1) % ENTITY_COUNT;
                    free_ids--;
                    live_total++;
                    alive_ids.insert(alive_ids.size(), id);
                    push_beat(ST_OK, id, 1'b0, '0, 1'b1);
                end
            end
            REQ_DESTROY:
            begin
                if (free_ids >= ENTITY_COUNT)
                begin
                    push_beat(ST_ALL_FREE, 0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    // no liveness check: a dead id is pushed again
                    if (ent_ok)
                    begin
                        sig_table[ent] = '0;
                        free_ring[ring_tail] = eidx_t'(ent);
                        ring_tail = (ring_tail + 1) % ENTITY_COUNT;
                        free_ids++;
                        if (live_total > 0)
                            live_total--;
                        found = alive_ids.find_first_index(x) with (x == ent);
                        if (found.size() != 0)
                            alive_ids.delete(found[0]);
                    end
                    push_beat(ST_OK, 0, 1'b0, '0, 1'b1);
                end
            end
            REQ_ADD:
            begin
                if (ent_ok && comp_ok)
                    sig_table[ent][comp] = 1'b1;
                push_beat(ST_OK, 0, 1'b0, '0, 1'b1);
            end
            REQ_SET:
            begin
                if (ent_ok)
                    sig_table[ent] = sig_t'(val);
                push_beat(ST_OK, 0, 1'b0, '0, 1'b1);
            end
            REQ_READ:
            begin
                push_beat(ST_OK, 0, 1'b0, ent_ok ? VAL_W'(sig_table[ent]) : '0, 1'b1);
            end
            REQ_QUERY:
            begin
                hits = 0;
                for (int i = 0; i < ENTITY_COUNT; i++)
                    if (comp_ok && sig_table[i][comp])
                        hits++;
                if (hits == 0)
                begin
                    push_beat(ST_OK, 0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    seen = 0;
                    for (int i = 0; i < ENTITY_COUNT; i++)
                    begin
                        if (sig_table[i][comp])
                        begin
                            seen++;
                            push_beat(ST_OK, i, 1'b1, '0, seen == hits);
                        end
                    end
                end
            end
            default:
            begin
                push_beat(ST_OK, 0, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input rsp_beat_t got,
                                   input rsp_beat_t want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display({"%0t %s: got st=%0d ent=%0d hit=%0b sig=%h live=%0d last=%0b,",
                      " want st=%0d ent=%0d hit=%0b sig=%h live=%0d last=%0b"},
                     $time, what, got.status, got.entity, got.hit, got.sig, got.live,
                     got.last, want.status, want.entity, want.hit, want.sig, want.live,
                     want.last);
    endtask

    task automatic check_beat();
        rsp_beat_t got;
        rsp_beat_t want;
        got.status = rsp_ch.status;
        got.entity = rsp_ch.result_entity;
        got.hit    = rsp_ch.match_found;
        got.sig    = rsp_ch.signature_out;
        got.live   = rsp_ch.living_count;
        got.last   = rsp_ch.last;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch("unexpected beat", got, '0);
        end
        else
        begin
            want = pending_rsp.pop_front();
            if (got !== want)
                report_mismatch("beat mismatch", got, want);
        end
    endtask

    // Response side: checks every beat, stalls at random or for a requested stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_beat();
            if (hold_pending > 0)
            begin
                hold_cnt = hold_pending;
                hold_pending = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Drives one request and returns at the edge it is accepted; valid stays up
    task automatic send_request(input logic [REQ_W-1:0] kind, input int ent, input int comp,
                                input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.entity_id       <= ENT_W'(ent);
        req_ch.component_id    <= COMP_W'(comp);
        req_ch.signature_value <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(kind, ent, comp, val);
    endtask

    task automatic test_directed_cases();
        send_request(REQ_DESTROY, 5, 0, '0);             // nothing live yet
        send_request(REQ_CREATE, 0, 0, '0);
        send_request(REQ_CREATE, 0, 0, '0);
        send_request(REQ_READ, 0, 0, '0);
        send_request(REQ_SET, 0, 0, '1);
        send_request(REQ_READ, 0, 0, '0);
        send_request(REQ_ADD, 1, COMP_MAX, '0);
        send_request(REQ_ADD, 1, 0, '0);
        send_request(REQ_READ, 1, 0, '0);
        send_request(REQ_QUERY, 0, COMP_MAX, '0);
        send_request(REQ_QUERY, 0, 0, '0);
        send_request(REQ_SET, ENT_MAX, 0, 32'h0002_0000); // entity never created
        send_request(REQ_QUERY, 0, 17, '0);
        send_request(REQ_SET, 0, 0, '0);
        send_request(REQ_QUERY, 0, 5, '0);                // no match
        send_request(REQ_RSVD_A, ENT_MAX, COMP_MAX, '1);
        send_request(REQ_RSVD_B, 0, 0, '0);
        send_request(REQ_DESTROY, ENT_MAX, 0, '0);        // not live
        send_request(REQ_READ, ENT_MAX, 0, '0);
        send_request(REQ_DESTROY, 0, 0, '0);
        send_request(REQ_CREATE, 0, 0, '0);
        send_request(REQ_SET, ENT_MAX, 0, 32'hA5A5_5A5A);
        send_request(REQ_READ, ENT_MAX, 0, '0);
    endtask

    task automatic test_pool_exhaustion();
        int pick;
        while (free_ids > 0)
        begin
            send_request(REQ_CREATE, 0, 0, '0);
            if ($urandom_range(0, 2) == 0)
                send_request(REQ_ADD, alive_ids[$], $urandom_range(0, COMP_MAX), '0);
        end
        send_request(REQ_CREATE, 0, 0, '0);
        send_request(REQ_QUERY, 0, $urandom_range(0, COMP_MAX), '0);
        send_request(REQ_CREATE, 0, 0, '0);
        while (free_ids < ENTITY_COUNT)
        begin
            if (alive_ids.size() != 0)
                pick = alive_ids[$urandom_range(0, alive_ids.size() - 1)];
            else
                pick = $urandom_range(0, ENT_MAX);
            send_request(REQ_DESTROY, pick, 0, '0);
        end
        send_request(REQ_DESTROY, $urandom_range(0, ENT_MAX), 0, '0);
    endtask

    // Long response stall while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        hold_pending = 200;
        repeat (4)
        begin
            send_request(REQ_CREATE, 0, 0, '0);
            send_request(REQ_SET, alive_ids.size() != 0 ? alive_ids[$] : 0, 0, $urandom);
            send_request(REQ_QUERY, 0, $urandom_range(0, COMP_MAX), '0);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int roll;
        int ent;
        int comp;
        logic [VAL_W-1:0] val;
        logic [REQ_W-1:0] kind;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (alive_ids.size() != 0 && $urandom_range(0, 3) != 0)
                ent = alive_ids[$urandom_range(0, alive_ids.size() - 1)];
            else
                ent = $urandom_range(0, ENT_MAX);
            comp = $urandom_range(0, COMP_MAX);
            if ($urandom_range(0, 1) == 1)
                val = $urandom;
            else
                val = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
            if (roll < 20)
                kind = REQ_CREATE;
            else if (roll < 35)
                kind = REQ_DESTROY;
            else if (roll < 55)
                kind = REQ_ADD;
            else if (roll < 67)
                kind = REQ_SET;
            else if (roll < 80)
                kind = REQ_READ;
            else if (roll < 95)
                kind = REQ_QUERY;
            else
                kind = $urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B;
            send_request(kind, ent, comp, val);
        end
    endtask

    initial
    begin
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_CREATE;
        req_ch.entity_id       <= '0;
        req_ch.component_id    <= '0;
        req_ch.signature_value <= '0;
        rst_n                  <= 1'b0;
        err_count    = 0;
        hold_pending = 0;
        tx_idle_pct  = 19;
        rx_idle_pct  = 48;
        reset_table_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_pool_exhaustion();
        test_random_traffic(10);
        tx_idle_pct = 48;
        rx_idle_pct = 19;
        test_random_traffic(10);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(10);

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/eidst_pkg.sv
sv/eidst_if.sv
sv/eidst_ram.sv
sv/eidst_freeq.sv
sv/entity_id_allocator_signature_table.sv
bench/testbench.sv
